// ----- hdl/bal_pkg.sv -----
// ----------------------------------------------------------------------------
// bal_pkg
// Shared sizes, codes and controller/datapath interface types for the
// bounded array list.
// ----------------------------------------------------------------------------
package bal_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = 8;
	localparam int DATA_W   = 32;

	typedef enum logic [2:0] {
		ACT_APPEND = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_READ   = 3'd3,
		ACT_WRITE  = 3'd4,
		ACT_SWAP   = 3'd5,
		ACT_FIND   = 3'd6,
		ACT_CLEAR  = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} st_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_DRAIN,
		S_FIN_WR,
		S_RD_CAP,
		S_SW_B,
		S_SW_WA,
		S_SW_WB,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_PTR,
		RD_A,
		RD_B
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_VAL_A,
		WR_VAL_CNT,
		WR_RD_A,
		WR_TMP_B
	} wr_sel_t;

	typedef struct packed {
		logic    load;
		logic    scan_start;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    cap_tmp;
		logic    finish;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic err;
		logic more;
		logic out_busy;
	} sts_t;

endpackage

// ----- hdl/bal_ram.sv -----
// ----------------------------------------------------------------------------
// bal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/bal_ctrl.sv -----
// ----------------------------------------------------------------------------
// bal_ctrl
// Request sequencer: steps each request through its memory accesses and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module bal_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  bal_pkg::sts_t  sts,
	output bal_pkg::cmd_t  cmd
);

	bal_pkg::state_t state_q;
	bal_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bal_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		cmd.rd_sel     = bal_pkg::RD_NONE;
		cmd.wr_sel     = bal_pkg::WR_NONE;
		in_stall       = 1'b1;
		case (state_q)
			bal_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = bal_pkg::S_CHECK;
				end
			end
			bal_pkg::S_CHECK: begin
				state_nxt = bal_pkg::S_DONE;
				if (!sts.err) begin
					case (sts.act)
						bal_pkg::ACT_APPEND: cmd.wr_sel = bal_pkg::WR_VAL_CNT;
						bal_pkg::ACT_INSERT,
						bal_pkg::ACT_REMOVE,
						bal_pkg::ACT_FIND: begin
							cmd.scan_start = 1'b1;
							state_nxt      = bal_pkg::S_SCAN;
						end
						bal_pkg::ACT_READ: begin
							cmd.rd_sel = bal_pkg::RD_A;
							state_nxt  = bal_pkg::S_RD_CAP;
						end
						bal_pkg::ACT_WRITE: cmd.wr_sel = bal_pkg::WR_VAL_A;
						bal_pkg::ACT_SWAP: begin
							cmd.rd_sel = bal_pkg::RD_A;
							state_nxt  = bal_pkg::S_SW_B;
						end
						default: state_nxt = bal_pkg::S_DONE;
					endcase
				end
			end
			bal_pkg::S_SCAN: begin
				if (sts.more) begin
					cmd.rd_sel = bal_pkg::RD_PTR;
				end else begin
					state_nxt = bal_pkg::S_DRAIN;
				end
			end
			bal_pkg::S_DRAIN: begin
				if (sts.act == bal_pkg::ACT_INSERT) begin
					state_nxt = bal_pkg::S_FIN_WR;
				end else begin
					state_nxt = bal_pkg::S_DONE;
				end
			end
			bal_pkg::S_FIN_WR: begin
				cmd.wr_sel = bal_pkg::WR_VAL_A;
				state_nxt  = bal_pkg::S_DONE;
			end
			bal_pkg::S_RD_CAP: begin
				cmd.cap_tmp = 1'b1;
				state_nxt   = bal_pkg::S_DONE;
			end
			bal_pkg::S_SW_B: begin
				cmd.cap_tmp = 1'b1;
				cmd.rd_sel  = bal_pkg::RD_B;
				state_nxt   = bal_pkg::S_SW_WA;
			end
			bal_pkg::S_SW_WA: begin
				cmd.wr_sel = bal_pkg::WR_RD_A;
				state_nxt  = bal_pkg::S_SW_WB;
			end
			bal_pkg::S_SW_WB: begin
				cmd.wr_sel = bal_pkg::WR_TMP_B;
				state_nxt  = bal_pkg::S_DONE;
			end
			bal_pkg::S_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_nxt  = bal_pkg::S_IDLE;
				end
			end
			default: state_nxt = bal_pkg::S_IDLE;
		endcase
	end

endmodule

// ----- hdl/bal_dp.sv -----
// ----------------------------------------------------------------------------
// bal_dp
// List datapath: request latch, entry count, walk pointer, list memory,
// shift and compare logic, and the result register.
// ----------------------------------------------------------------------------
module bal_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bal_pkg::cmd_t                        cmd,
	output bal_pkg::sts_t                        sts,
	input  logic [2:0]                           action,
	input  logic [bal_pkg::IDX_W-1:0]            index_a,
	input  logic [bal_pkg::IDX_W-1:0]            index_b,
	input  logic signed [bal_pkg::DATA_W-1:0]    value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic signed [bal_pkg::DATA_W-1:0]    read_value,
	output logic [bal_pkg::IDX_W-1:0]            found_index,
	output logic [bal_pkg::CNT_W-1:0]            item_count
);

	bal_pkg::act_t                   act_q;
	logic [bal_pkg::IDX_W-1:0]       ia_q;
	logic [bal_pkg::IDX_W-1:0]       ib_q;
	logic [bal_pkg::DATA_W-1:0]      val_q;
	logic [bal_pkg::CNT_W-1:0]       cnt_q;
	logic [bal_pkg::CNT_W-1:0]       ptr_q;
	logic                            more_q;
	logic                            pend_s1;
	logic [bal_pkg::ADDR_W-1:0]      addr_s1;
	logic [bal_pkg::DATA_W-1:0]      tmp_q;
	logic                            hit_q;
	logic [bal_pkg::IDX_W-1:0]       fidx_q;
	logic                            out_valid_q;
	bal_pkg::st_t                    status_q;
	logic [bal_pkg::DATA_W-1:0]      read_value_q;
	logic [bal_pkg::IDX_W-1:0]       found_index_q;
	logic [bal_pkg::CNT_W-1:0]       item_count_q;

	logic [bal_pkg::CNT_W-1:0]       ia_ext;
	logic [bal_pkg::CNT_W-1:0]       ib_ext;
	logic [bal_pkg::CNT_W-1:0]       ia_inc;
	logic [bal_pkg::CNT_W-1:0]       ptr_inc;
	logic                            err;
	bal_pkg::st_t                    err_code;
	bal_pkg::st_t                    st_fin;
	logic [bal_pkg::CNT_W-1:0]       cnt_nxt;

	logic                            we;
	logic [bal_pkg::ADDR_W-1:0]      waddr;
	logic [bal_pkg::DATA_W-1:0]      wdata;
	logic                            re;
	logic [bal_pkg::ADDR_W-1:0]      raddr;
	logic [bal_pkg::DATA_W-1:0]      rdata;

	assign ia_ext  = bal_pkg::CNT_W'(ia_q);
	assign ib_ext  = bal_pkg::CNT_W'(ib_q);
	assign ia_inc  = ia_ext + bal_pkg::CNT_W'(1);
	assign ptr_inc = ptr_q + bal_pkg::CNT_W'(1);

	always_comb begin
		err      = 1'b0;
		err_code = bal_pkg::ST_OK;
		case (act_q)
			bal_pkg::ACT_APPEND: begin
				if (cnt_q >= bal_pkg::CNT_W'(bal_pkg::CAPACITY)) begin
					err      = 1'b1;
					err_code = bal_pkg::ST_FULL;
				end
			end
			bal_pkg::ACT_INSERT: begin
				if (ia_ext > cnt_q) begin
					err      = 1'b1;
					err_code = bal_pkg::ST_RANGE;
				end else if (cnt_q >= bal_pkg::CNT_W'(bal_pkg::CAPACITY)) begin
					err      = 1'b1;
					err_code = bal_pkg::ST_FULL;
				end
			end
			bal_pkg::ACT_REMOVE,
			bal_pkg::ACT_READ,
			bal_pkg::ACT_WRITE: begin
				if (ia_ext >= cnt_q) begin
					err      = 1'b1;
					err_code = bal_pkg::ST_RANGE;
				end
			end
			bal_pkg::ACT_SWAP: begin
				if (ia_ext >= cnt_q || ib_ext >= cnt_q) begin
					err      = 1'b1;
					err_code = bal_pkg::ST_RANGE;
				end
			end
			default: err = 1'b0;
		endcase
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (!err) begin
			case (act_q)
				bal_pkg::ACT_APPEND,
				bal_pkg::ACT_INSERT: cnt_nxt = cnt_q + bal_pkg::CNT_W'(1);
				bal_pkg::ACT_REMOVE: cnt_nxt = cnt_q - bal_pkg::CNT_W'(1);
				bal_pkg::ACT_CLEAR:  cnt_nxt = '0;
				default:             cnt_nxt = cnt_q;
			endcase
		end
	end

	always_comb begin
		if (err) begin
			st_fin = err_code;
		end else if (act_q == bal_pkg::ACT_FIND && !hit_q) begin
			st_fin = bal_pkg::ST_NOTFOUND;
		end else begin
			st_fin = bal_pkg::ST_OK;
		end
	end

	// shift write of the word read in the previous cycle takes the port first
	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = rdata;
		if (pend_s1 && act_q != bal_pkg::ACT_FIND) begin
			we = 1'b1;
			if (act_q == bal_pkg::ACT_INSERT) begin
				waddr = addr_s1 + bal_pkg::ADDR_W'(1);
			end else begin
				waddr = addr_s1 - bal_pkg::ADDR_W'(1);
			end
		end else begin
			case (cmd.wr_sel)
				bal_pkg::WR_VAL_A: begin
					we    = 1'b1;
					waddr = bal_pkg::ADDR_W'(ia_q);
					wdata = val_q;
				end
				bal_pkg::WR_VAL_CNT: begin
					we    = 1'b1;
					waddr = cnt_q[bal_pkg::ADDR_W-1:0];
					wdata = val_q;
				end
				bal_pkg::WR_RD_A: begin
					we    = 1'b1;
					waddr = bal_pkg::ADDR_W'(ia_q);
					wdata = rdata;
				end
				bal_pkg::WR_TMP_B: begin
					we    = 1'b1;
					waddr = bal_pkg::ADDR_W'(ib_q);
					wdata = tmp_q;
				end
				default: we = 1'b0;
			endcase
		end
	end

	always_comb begin
		re    = 1'b1;
		raddr = ptr_q[bal_pkg::ADDR_W-1:0];
		case (cmd.rd_sel)
			bal_pkg::RD_PTR: raddr = ptr_q[bal_pkg::ADDR_W-1:0];
			bal_pkg::RD_A:   raddr = bal_pkg::ADDR_W'(ia_q);
			bal_pkg::RD_B:   raddr = bal_pkg::ADDR_W'(ib_q);
			default:         re    = 1'b0;
		endcase
	end

	bal_ram #(
		.WIDTH(bal_pkg::DATA_W),
		.DEPTH(bal_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= bal_pkg::act_t'(action);
			ia_q  <= index_a;
			ib_q  <= index_b;
			val_q <= $unsigned(value);
		end
		if (cmd.scan_start) begin
			case (act_q)
				bal_pkg::ACT_INSERT: ptr_q <= cnt_q - bal_pkg::CNT_W'(1);
				bal_pkg::ACT_REMOVE: ptr_q <= ia_inc;
				default:             ptr_q <= '0;
			endcase
		end else if (cmd.rd_sel == bal_pkg::RD_PTR) begin
			if (act_q == bal_pkg::ACT_INSERT) begin
				ptr_q <= ptr_q - bal_pkg::CNT_W'(1);
			end else begin
				ptr_q <= ptr_inc;
			end
		end
		addr_s1 <= ptr_q[bal_pkg::ADDR_W-1:0];
		if (cmd.cap_tmp) begin
			tmp_q <= rdata;
		end
		if (cmd.load) begin
			fidx_q <= '0;
		end else if (pend_s1 && act_q == bal_pkg::ACT_FIND && !hit_q && rdata == val_q) begin
			fidx_q <= bal_pkg::IDX_W'(addr_s1);
		end
		if (cmd.finish) begin
			status_q      <= st_fin;
			read_value_q  <= (act_q == bal_pkg::ACT_READ && !err) ? tmp_q : '0;
			found_index_q <= (act_q == bal_pkg::ACT_FIND) ? fidx_q : '0;
			item_count_q  <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			more_q      <= 1'b0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				cnt_q <= cnt_nxt;
			end
			if (cmd.scan_start) begin
				case (act_q)
					bal_pkg::ACT_INSERT: more_q <= cnt_q > ia_ext;
					bal_pkg::ACT_REMOVE: more_q <= ia_inc < cnt_q;
					default:             more_q <= cnt_q != '0;
				endcase
			end else if (cmd.rd_sel == bal_pkg::RD_PTR) begin
				if (act_q == bal_pkg::ACT_INSERT) begin
					more_q <= ptr_q > ia_ext;
				end else begin
					more_q <= ptr_inc < cnt_q;
				end
			end
			pend_s1 <= (cmd.rd_sel == bal_pkg::RD_PTR);
			if (cmd.load) begin
				hit_q <= 1'b0;
			end else if (pend_s1 && act_q == bal_pkg::ACT_FIND && rdata == val_q) begin
				hit_q <= 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.act      = act_q;
	assign sts.err      = err;
	assign sts.more     = more_q;
	assign sts.out_busy = out_valid_q && out_stall;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = $signed(read_value_q);
	assign found_index = found_index_q;
	assign item_count  = item_count_q;

endmodule

// ----- hdl/bounded_array_list.sv -----
// ----------------------------------------------------------------------------
// bounded_array_list
// Ordered list of up to 256 signed 32-bit words with append, insert, remove,
// read, write, swap, find and clear requests; one result word per request.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Insert, remove and find walk the
// stored entries (up to 256) through the single read and single write port
// of the list memory, one entry per cycle. The next request is taken as
// soon as the result is loaded into the output register, even if that
// result is still stalled; a second result waits in the sequencer until
// the output register is free.
module bounded_array_list (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        action,
	input  logic [bal_pkg::IDX_W-1:0]         index_a,
	input  logic [bal_pkg::IDX_W-1:0]         index_b,
	input  logic signed [bal_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [bal_pkg::DATA_W-1:0] read_value,
	output logic [bal_pkg::IDX_W-1:0]         found_index,
	output logic [bal_pkg::CNT_W-1:0]         item_count
);

	bal_pkg::cmd_t cmd;
	bal_pkg::sts_t sts;

	bal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bal_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.index_a     (index_a),
		.index_b     (index_b),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_value  (read_value),
		.found_index (found_index),
		.item_count  (item_count)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while a request was in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> item_count <= bal_pkg::CNT_W'(bal_pkg::CAPACITY))
		else $error("item count beyond capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != bal_pkg::ST_OK) |-> (found_index == '0 && read_value == '0))
		else $error("failed request returned a nonzero word");

	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish) |=> !in_stall)
		else $error("sequencer did not return to idle after a result");

endmodule

// ----- verif/tb_bounded_array_list.sv -----
// ----------------------------------------------------------------------------
// tb_bounded_array_list
// Self-checking bench for the bounded array list. A shadow copy of the list
// predicts status, read word, found position and count for every accepted
// request; result words are checked in order against it. Directed corner
// requests come first, then random request streams under several idle and
// stall mixes, including a full list and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_bounded_array_list;

	localparam int HOLD_CYCLES  = 1500;
	localparam int DRAIN_CYCLES = bal_pkg::CAPACITY + 40;

	typedef struct {
		bal_pkg::st_t                      status;
		logic signed [bal_pkg::DATA_W-1:0] read_value;
		logic [bal_pkg::IDX_W-1:0]         found_index;
		logic [bal_pkg::CNT_W-1:0]         item_count;
	} list_reply_t;

	class list_mirror;
		logic signed [bal_pkg::DATA_W-1:0] words[bal_pkg::CAPACITY];
		int unsigned                       count;
		list_reply_t                       replies_due[$];
		int unsigned                       mismatches;

		function new();
			count = 0;
			mismatches = 0;
		endfunction

		function void take_request(bal_pkg::act_t act, logic [bal_pkg::IDX_W-1:0] ia,
				logic [bal_pkg::IDX_W-1:0] ib, logic signed [bal_pkg::DATA_W-1:0] val);
			list_reply_t                       r;
			int unsigned                       i;
			logic signed [bal_pkg::DATA_W-1:0] t;
			r.status = bal_pkg::ST_OK;
			r.read_value = '0;
			r.found_index = '0;
			case (act)
				bal_pkg::ACT_APPEND: begin
					if (count >= bal_pkg::CAPACITY) begin
						r.status = bal_pkg::ST_FULL;
					end else begin
						words[count] = val;
						count++;
					end
				end
				bal_pkg::ACT_INSERT: begin
					if (ia > count) begin
						r.status = bal_pkg::ST_RANGE;
					end else if (count >= bal_pkg::CAPACITY) begin
						r.status = bal_pkg::ST_FULL;
					end else begin
						for (i = count; i > ia; i--)
							words[i] = words[i - 1];
						words[ia] = val;
						count++;
					end
				end
				bal_pkg::ACT_REMOVE: begin
					if (ia >= count) begin
						r.status = bal_pkg::ST_RANGE;
					end else begin
						for (i = ia; i + 1 < count; i++)
							words[i] = words[i + 1];
						count--;
					end
				end
				bal_pkg::ACT_READ: begin
					if (ia >= count)
						r.status = bal_pkg::ST_RANGE;
					else
						r.read_value = words[ia];
				end
				bal_pkg::ACT_WRITE: begin
					if (ia >= count)
						r.status = bal_pkg::ST_RANGE;
					else
						words[ia] = val;
				end
				bal_pkg::ACT_SWAP: begin
					if (ia >= count || ib >= count) begin
						r.status = bal_pkg::ST_RANGE;
					end else begin
						t = words[ia];
						words[ia] = words[ib];
						words[ib] = t;
					end
				end
				bal_pkg::ACT_FIND: begin
					r.status = bal_pkg::ST_NOTFOUND;
					for (i = 0; i < count; i++) begin
						if (words[i] == val) begin
							r.status = bal_pkg::ST_OK;
							r.found_index = bal_pkg::IDX_W'(i);
							break;
						end
					end
				end
				default: begin
					count = 0;
				end
			endcase
			r.item_count = bal_pkg::CNT_W'(count);
			replies_due.push_back(r);
		endfunction

		function void check_reply(logic [1:0] st, logic signed [bal_pkg::DATA_W-1:0] rd,
				logic [bal_pkg::IDX_W-1:0] fi, logic [bal_pkg::CNT_W-1:0] cnt);
			list_reply_t r;
			if (replies_due.size() == 0) begin
				$error("result word with no request pending");
				mismatches++;
				return;
			end
			r = replies_due.pop_front();
			if (st !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, st);
				mismatches++;
			end
			if (rd !== r.read_value) begin
				$error("read_value: expected %0d, got %0d", r.read_value, rd);
				mismatches++;
			end
			if (fi !== r.found_index) begin
				$error("found_index: expected %0d, got %0d", r.found_index, fi);
				mismatches++;
			end
			if (cnt !== r.item_count) begin
				$error("item_count: expected %0d, got %0d", r.item_count, cnt);
				mismatches++;
			end
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic [2:0]                        action;
	logic [bal_pkg::IDX_W-1:0]         index_a;
	logic [bal_pkg::IDX_W-1:0]         index_b;
	logic signed [bal_pkg::DATA_W-1:0] value;
	logic                              out_valid;
	logic                              out_stall;
	logic [1:0]                        status;
	logic signed [bal_pkg::DATA_W-1:0] read_value;
	logic [bal_pkg::IDX_W-1:0]         found_index;
	logic [bal_pkg::CNT_W-1:0]         item_count;

	list_mirror mirror;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_left = 0;

	bounded_array_list DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.index_a    (index_a),
		.index_b    (index_b),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.found_index(found_index),
		.item_count (item_count)
	);

	always #1 clk = ~clk;

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mirror.check_reply(status, read_value, found_index, item_count);
	end

	task automatic send_request(bal_pkg::act_t a, logic [bal_pkg::IDX_W-1:0] ia,
			logic [bal_pkg::IDX_W-1:0] ib, logic signed [bal_pkg::DATA_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		index_a <= ia;
		index_b <= ib;
		value <= v;
		do
			@(posedge clk);
		while (in_stall);
		mirror.take_request(a, ia, ib, v);
		@(negedge clk);
	endtask

	function automatic logic [bal_pkg::IDX_W-1:0] pick_index(int unsigned n, bit upto_count);
		int unsigned span;
		if ($urandom_range(9) == 0 || (n == 0 && !upto_count))
			return bal_pkg::IDX_W'($urandom_range(255));
		if ($urandom_range(19) == 0 && n <= 255)
			return bal_pkg::IDX_W'(n);
		span = upto_count ? n : n - 1;
		if (span > 255)
			span = 255;
		return bal_pkg::IDX_W'($urandom_range(span));
	endfunction

	task automatic send_random();
		bal_pkg::act_t                     a;
		int unsigned                       pick;
		int unsigned                       n;
		logic signed [bal_pkg::DATA_W-1:0] v;
		n = mirror.count;
		pick = $urandom_range(99);
		if (pick < 20)
			a = bal_pkg::ACT_APPEND;
		else if (pick < 38)
			a = bal_pkg::ACT_INSERT;
		else if (pick < 52)
			a = bal_pkg::ACT_REMOVE;
		else if (pick < 64)
			a = bal_pkg::ACT_READ;
		else if (pick < 74)
			a = bal_pkg::ACT_WRITE;
		else if (pick < 82)
			a = bal_pkg::ACT_SWAP;
		else if (pick < 97)
			a = bal_pkg::ACT_FIND;
		else
			a = bal_pkg::ACT_CLEAR;
		v = $urandom;
		if (a == bal_pkg::ACT_FIND && n != 0 && $urandom_range(1) == 1)
			v = mirror.words[$urandom_range(n - 1)];
		send_request(a, pick_index(n, a == bal_pkg::ACT_INSERT), pick_index(n, 1'b0), v);
	endtask

	task automatic fill_list();
		while (mirror.count < bal_pkg::CAPACITY) begin
			if ($urandom_range(3) == 0)
				send_request(bal_pkg::ACT_INSERT, pick_index(mirror.count, 1'b1), '0,
					$urandom);
			else
				send_request(bal_pkg::ACT_APPEND, '0, '0, $urandom);
		end
		send_request(bal_pkg::ACT_APPEND, '0, '0, $urandom);
		send_request(bal_pkg::ACT_INSERT, '0, '0, $urandom);
		send_request(bal_pkg::ACT_INSERT, 8'd255, '0, $urandom);
		send_request(bal_pkg::ACT_FIND, '0, '0, mirror.words[bal_pkg::CAPACITY - 1]);
	endtask

	task automatic run_random(int n);
		repeat (n) send_random();
	endtask

	initial begin
		mirror = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = bal_pkg::ACT_APPEND;
		index_a = '0;
		index_b = '0;
		value = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(bal_pkg::ACT_READ, 8'd0, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_REMOVE, 8'd0, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_WRITE, 8'd0, 8'd0, 32'sd7);
		send_request(bal_pkg::ACT_SWAP, 8'd0, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_FIND, 8'd0, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_INSERT, 8'd1, 8'd0, 32'sd1);
		send_request(bal_pkg::ACT_INSERT, 8'd0, 8'd0, 32'h7fffffff);
		send_request(bal_pkg::ACT_APPEND, 8'd0, 8'd0, 32'h80000000);
		send_request(bal_pkg::ACT_APPEND, 8'd255, 8'd255, -32'sd1);
		send_request(bal_pkg::ACT_INSERT, 8'd3, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_INSERT, 8'd1, 8'd0, 32'sd12345);
		send_request(bal_pkg::ACT_READ, 8'd255, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_READ, 8'd0, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_READ, 8'd4, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_WRITE, 8'd2, 8'd0, 32'h55555555);
		send_request(bal_pkg::ACT_SWAP, 8'd0, 8'd4, 32'sd0);
		send_request(bal_pkg::ACT_SWAP, 8'd1, 8'd1, 32'sd0);
		send_request(bal_pkg::ACT_SWAP, 8'd255, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_FIND, 8'd0, 8'd0, -32'sd1);
		send_request(bal_pkg::ACT_FIND, 8'd0, 8'd0, 32'h80000000);
		send_request(bal_pkg::ACT_FIND, 8'd0, 8'd0, 32'sd42);
		send_request(bal_pkg::ACT_REMOVE, 8'd0, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_REMOVE, 8'd3, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_REMOVE, 8'd1, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_CLEAR, 8'd0, 8'd0, 32'sd0);
		send_request(bal_pkg::ACT_READ, 8'd0, 8'd0, 32'sd0);

		fill_list();
		hold_left = HOLD_CYCLES;
		run_random(250);

		send_idle_pct = 51;
		run_random(380);

		send_idle_pct = 0;
		recv_stall_pct = 51;
		run_random(380);

		send_idle_pct = 34;
		recv_stall_pct = 34;
		run_random(300);

		in_valid <= 1'b0;
		while (mirror.replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/bal_pkg.sv
hdl/bal_ram.sv
hdl/bal_ctrl.sv
hdl/bal_dp.sv
hdl/bounded_array_list.sv
verif/tb_bounded_array_list.sv
